@@ hdl/bitmap_slot_allocator_core_defines.svh @@
// Assertion macros shared by the allocator RTL
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define BSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bsa_pkg.sv @@
`default_nettype none

package bsa_pkg;

    // Width of the slot number fields
    localparam int SLOT_W = 11;

    // Bits per group in the two-step lowest-free-bit search
    localparam int GROUP_BITS = 8;

    // Fixed-point shift for the slot-to-word reciprocal divide
    localparam int DIV_SHIFT = 18;

    // Request codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] slot_to_release;
    } t_request;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              status;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/bitmap_slot_allocator_core.sv @@
// Allocate: reads and checks words from the first-fit pointer upward (S_RD, S_CHK) until one
//   has a free bit, then marks it (S_PICK) and pulses o_done; with no slot free, reports full after the last word.
// Release: works out word and bit (S_REL_DV, S_REL_FX), reads and clears the bit (S_REL_RD, S_REL_WR), pulses o_done.
// One request at a time; a new request is taken in the cycle its predecessor's result shows.
// The receiver cannot stall; o_result shows the result with o_done and holds it until the next result.
// Reset clears the bitmap one word a cycle (WORD_COUNT words, 32 by default), busy high.
`default_nettype none

`include "bitmap_slot_allocator_core_defines.svh"

module bitmap_slot_allocator_core #(
    parameter int SLOTS     = 2048,
    parameter int WORD_BITS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire bsa_pkg::t_request i_request,
    output logic                busy,
    output logic                o_done,
    output bsa_pkg::t_result    o_result
);

    localparam int WORD_COUNT = (SLOTS - 1) / WORD_BITS + 1;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int LAST_WORD  = WORD_COUNT - 1;
    localparam int LAST_BITS  = SLOTS - LAST_WORD * WORD_BITS;
    localparam int GROUPS     = (WORD_BITS + bsa_pkg::GROUP_BITS - 1) / bsa_pkg::GROUP_BITS;
    localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD_BITS   = GROUPS * bsa_pkg::GROUP_BITS;
    localparam int IN_W       = $clog2(bsa_pkg::GROUP_BITS);
    localparam int BIT_W      = GRP_W + IN_W;
    localparam int BP_W       = $clog2(WORD_BITS);
    localparam int GS_W       = WIDX_W + 7;
    localparam int CMP_W      = 18;
    localparam int RECIP      = ((1 << bsa_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W     = bsa_pkg::SLOT_W + bsa_pkg::DIV_SHIFT;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_RD     = 9'b000000100,
        S_CHK    = 9'b000001000,
        S_PICK   = 9'b000010000,
        S_REL_DV = 9'b000100000,
        S_REL_FX = 9'b001000000,
        S_REL_RD = 9'b010000000,
        S_REL_WR = 9'b100000000
    } t_state;

    t_state                         r_state, n_state;
    logic [WIDX_W-1:0]              r_addr, n_addr;
    logic [WIDX_W-1:0]              r_hint, n_hint;
    logic [PAD_BITS-1:0]            r_free, n_free;
    logic [GRP_W-1:0]               r_grp, n_grp;
    logic [bsa_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [bsa_pkg::SLOT_W-1:0]     r_q, n_q;
    logic [BP_W-1:0]                r_bitpos, n_bitpos;
    logic                           r_rel_ok, n_rel_ok;
    logic                           r_done, n_done;
    bsa_pkg::t_result               r_result, n_result;

    // Bitmap storage
    logic [WORD_BITS-1:0]           r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0]           r_rd_data;
    logic                           rd_en;
    logic                           wr_en;
    logic [WORD_BITS-1:0]           wr_data;

    // Search and divide datapath
    logic [WORD_BITS-1:0]           usable;
    logic [PAD_BITS-1:0]            free_pad;
    logic [GROUPS-1:0]              grp_any;
    logic [GRP_W-1:0]               first_grp;
    logic [bsa_pkg::GROUP_BITS-1:0] grp_bits;
    logic [IN_W-1:0]                first_in;
    logic [BIT_W-1:0]               pick_bit;
    logic [GS_W-1:0]                granted;
    logic [PROD_W-1:0]              div_prod;
    logic [bsa_pkg::SLOT_W-1:0]     rem_full;
    logic                           slot_in_range;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_result;

    // Mark padding bits of the last word as unusable
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            usable[i] = (r_addr != WIDX_W'(LAST_WORD)) || (i < LAST_BITS);
        end
    end

    // First step of the search: find the lowest group holding a free bit
    always_comb begin
        free_pad  = PAD_BITS'(~r_rd_data & usable);
        first_grp = '0;
        for (int g = 0; g < GROUPS; g++) begin
            grp_any[g] = |free_pad[g*bsa_pkg::GROUP_BITS +: bsa_pkg::GROUP_BITS];
        end
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                first_grp = GRP_W'(g);
            end
        end
    end

    // Second step: lowest free bit inside the chosen group
    always_comb begin
        grp_bits = r_free[r_grp*bsa_pkg::GROUP_BITS +: bsa_pkg::GROUP_BITS];
        first_in = '0;
        for (int k = bsa_pkg::GROUP_BITS - 1; k >= 0; k--) begin
            if (grp_bits[k]) begin
                first_in = IN_W'(k);
            end
        end
        pick_bit = {r_grp, first_in};
        granted  = GS_W'(r_addr) * GS_W'(WORD_BITS) + GS_W'(pick_bit);
    end

    // Slot to word and bit: reciprocal multiply, exact for 11-bit slots
    always_comb begin
        div_prod      = PROD_W'(r_slot) * PROD_W'(RECIP);
        rem_full      = r_slot - bsa_pkg::SLOT_W'(r_q * bsa_pkg::SLOT_W'(WORD_BITS));
        slot_in_range = (CMP_W'(r_slot) < CMP_W'(SLOTS));
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_hint   = r_hint;
        n_free   = r_free;
        n_grp    = r_grp;
        n_slot   = r_slot;
        n_q      = r_q;
        n_bitpos = r_bitpos;
        n_rel_ok = r_rel_ok;
        n_done   = 1'b0;
        n_result = r_result;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_data  = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_addr == WIDX_W'(LAST_WORD)) begin
                    n_addr  = '0;
                    n_hint  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_slot = i_request.slot_to_release;
                    if (i_request.command == bsa_pkg::CMD_RELEASE) begin
                        n_state = S_REL_DV;
                    end else begin
                        n_addr  = r_hint;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                // Advance past full words; report full after the last one
                if (|free_pad) begin
                    n_free  = free_pad;
                    n_grp   = first_grp;
                    n_state = S_PICK;
                end else if (r_addr == WIDX_W'(LAST_WORD)) begin
                    n_hint                = r_addr;
                    n_done                = 1'b1;
                    n_result.granted_slot = '0;
                    n_result.status       = bsa_pkg::STATUS_FULL;
                    n_state               = S_IDLE;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = S_RD;
                end
            end
            S_PICK: begin
                wr_en                 = 1'b1;
                wr_data               = r_rd_data | (WORD_BITS'(1) << pick_bit);
                n_hint                = r_addr;
                n_done                = 1'b1;
                n_result.granted_slot = bsa_pkg::SLOT_W'(granted);
                n_result.status       = bsa_pkg::STATUS_OK;
                n_state               = S_IDLE;
            end
            S_REL_DV: begin
                n_q      = bsa_pkg::SLOT_W'(div_prod >> bsa_pkg::DIV_SHIFT);
                n_rel_ok = slot_in_range;
                n_state  = S_REL_FX;
            end
            S_REL_FX: begin
                n_addr   = WIDX_W'(r_q);
                n_bitpos = BP_W'(rem_full);
                n_state  = S_REL_RD;
            end
            S_REL_RD: begin
                rd_en   = r_rel_ok;
                n_state = S_REL_WR;
            end
            S_REL_WR: begin
                // Drop the bit and pull the first-fit pointer down if needed
                if (r_rel_ok) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd_data & ~(WORD_BITS'(1) << r_bitpos);
                    if (r_addr < r_hint) begin
                        n_hint = r_addr;
                    end
                end
                n_done                = 1'b1;
                n_result.granted_slot = r_slot;
                n_result.status       = bsa_pkg::STATUS_OK;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_hint  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_hint  <= n_hint;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_free   <= n_free;
        r_grp    <= n_grp;
        r_slot   <= n_slot;
        r_q      <= n_q;
        r_bitpos <= n_bitpos;
        r_rel_ok <= n_rel_ok;
        r_result <= n_result;
    end

    // Bitmap memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    `BSA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n,
                     start && !busy, busy,
                     "request accepted but block not busy")
    `BSA_ASSERT_SAME(a_pick_nonempty, i_clk, i_rst_n,
                     r_state == S_PICK, r_free != '0,
                     "pick with no free bit")
    `BSA_ASSERT_SAME(a_full_zero, i_clk, i_rst_n,
                     o_done && o_result.status == bsa_pkg::STATUS_FULL,
                     o_result.granted_slot == '0,
                     "full result with nonzero slot")
    `BSA_ASSERT_SAME(a_done_idle, i_clk, i_rst_n,
                     o_done, r_state == S_IDLE,
                     "result shown while sequencer busy")

endmodule

`default_nettype wire

@@ verif/tb_bitmap_slot_allocator_core.sv @@
`default_nettype none

module tb_bitmap_slot_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT   = 2048;
    localparam int WORD_WIDTH   = 64;
    localparam int WORD_TOTAL   = (SLOT_COUNT - 1) / WORD_WIDTH + 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 80;

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    bsa_pkg::t_request i_request = '0;
    logic              busy;
    logic              o_done;
    bsa_pkg::t_result  o_result;

    // Mirror of the occupancy bitmap, one bit per slot
    bit [WORD_WIDTH-1:0] occupancy [WORD_TOTAL];
    bsa_pkg::t_result    pending_grants [$];
    int                  error_count = 0;
    int                  stall_cycles = 0;
    bit                  sender_gaps = 1'b1;

    bitmap_slot_allocator_core #(
        .SLOTS     (SLOT_COUNT),
        .WORD_BITS (WORD_WIDTH)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (i_request),
        .busy      (busy),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Work out the grant for one request and update the mirrored bitmap
    function automatic bsa_pkg::t_result predict_grant(bsa_pkg::t_request req);
        bsa_pkg::t_result r;
        bit               found;
        r.granted_slot = '0;
        r.status       = bsa_pkg::STATUS_OK;
        if (req.command == bsa_pkg::CMD_RELEASE) begin
            if (req.slot_to_release < SLOT_COUNT) begin
                occupancy[req.slot_to_release / WORD_WIDTH]
                         [req.slot_to_release % WORD_WIDTH] = 1'b0;
            end
            r.granted_slot = req.slot_to_release;
        end else begin
            found    = 1'b0;
            r.status = bsa_pkg::STATUS_FULL;
            for (int w = 0; w < WORD_TOTAL && !found; w++) begin
                for (int b = 0; b < WORD_WIDTH && !found; b++) begin
                    if (w * WORD_WIDTH + b < SLOT_COUNT && !occupancy[w][b]) begin
                        occupancy[w][b] = 1'b1;
                        r.granted_slot  = bsa_pkg::SLOT_W'(w * WORD_WIDTH + b);
                        r.status        = bsa_pkg::STATUS_OK;
                        found           = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Present one request, hold it until taken, then maybe idle for a burst
    task automatic send_request(input logic cmd, input logic [bsa_pkg::SLOT_W-1:0] slot);
        bsa_pkg::t_request req;
        req.command         = cmd;
        req.slot_to_release = slot;
        start     <= 1'b1;
        i_request <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_grants.push_back(predict_grant(req));
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding grant has come back
    task automatic wait_grants_drained();
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    // Compare each result with the oldest outstanding prediction
    always @(posedge i_clk) begin
        bsa_pkg::t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result: granted_slot %0d status %0d",
                       o_result.granted_slot, o_result.status);
                error_count++;
            end else begin
                want = pending_grants.pop_front();
                if (o_result.granted_slot !== want.granted_slot) begin
                    $error("granted_slot: expected %0d, got %0d",
                           want.granted_slot, o_result.granted_slot);
                    error_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    error_count++;
                end
            end
        end
    end

    // Abort if neither a request nor a result moves for too long
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_bitmap_slot_allocator_core NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // First fit from an empty bitmap, with a hole reopened low down
    task automatic test_first_fit();
        send_request(bsa_pkg::CMD_ALLOC, '0);
        send_request(bsa_pkg::CMD_ALLOC, '1);
        send_request(bsa_pkg::CMD_ALLOC, bsa_pkg::SLOT_W'(1234));
        send_request(bsa_pkg::CMD_ALLOC, '0);
        send_request(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_W'(1));
        send_request(bsa_pkg::CMD_ALLOC, '1);
        send_request(bsa_pkg::CMD_ALLOC, '0);
    endtask

    // Release of free slots and of both ends of the slot range
    task automatic test_release_edges();
        send_request(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_W'(2));
        send_request(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_W'(2));
        send_request(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_W'(SLOT_COUNT - 1));
        send_request(bsa_pkg::CMD_RELEASE, '0);
        send_request(bsa_pkg::CMD_ALLOC, '0);
        send_request(bsa_pkg::CMD_RELEASE, '1);
        send_request(bsa_pkg::CMD_ALLOC, '1);
        send_request(bsa_pkg::CMD_RELEASE, '0);
    endtask

    // Drain mid-stream, then carry on from an idle block
    task automatic test_idle_pause();
        send_request(bsa_pkg::CMD_ALLOC,
                     bsa_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
        send_request(bsa_pkg::CMD_RELEASE, '0);
        wait_grants_drained();
        send_request(bsa_pkg::CMD_ALLOC,
                     bsa_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
        send_request(bsa_pkg::CMD_ALLOC,
                     bsa_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
    endtask

    // Fill every slot, allocate while full, then reopen single slots
    task automatic test_fill_to_full();
        int free_count;
        free_count = 0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!occupancy[s / WORD_WIDTH][s % WORD_WIDTH]) free_count++;
        end
        repeat (free_count + 3) begin
            send_request(bsa_pkg::CMD_ALLOC,
                         bsa_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
        end
        send_request(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_W'(SLOT_COUNT - 1));
        send_request(bsa_pkg::CMD_ALLOC, '0);
        send_request(bsa_pkg::CMD_RELEASE, '0);
        send_request(bsa_pkg::CMD_ALLOC, '1);
        send_request(bsa_pkg::CMD_RELEASE,
                     bsa_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
        send_request(bsa_pkg::CMD_ALLOC, '0);
        send_request(bsa_pkg::CMD_ALLOC, '0);
    endtask

    // Mixed traffic; the allocate share and idling change every hundred requests
    task automatic test_random_traffic(input int n_items, input bit allow_gaps);
        int alloc_pct;
        int region;
        int target;
        bit found;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                alloc_pct   = $urandom_range(10, 95);
                sender_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(1, 100) <= alloc_pct) begin
                send_request(bsa_pkg::CMD_ALLOC,
                             bsa_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
            end else begin
                // Aim mostly at taken slots, often low ones to pull the search back
                region = $urandom_range(0, 3);
                target = (region == 1) ? $urandom_range(0, 127)
                                       : $urandom_range(0, SLOT_COUNT - 1);
                found  = (region == 0);
                for (int k = 0; k < SLOT_COUNT && !found; k++) begin
                    if (occupancy[target / WORD_WIDTH][target % WORD_WIDTH]) begin
                        found = 1'b1;
                    end else begin
                        target = (target + 1) % SLOT_COUNT;
                    end
                end
                send_request(bsa_pkg::CMD_RELEASE, bsa_pkg::SLOT_W'(target));
            end
        end
    endtask

    initial begin
        foreach (occupancy[w]) occupancy[w] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_fit();
        test_release_edges();
        test_idle_pause();
        test_fill_to_full();
        test_random_traffic(100, 1'b1);
        test_random_traffic(60, 1'b0);

        wait_grants_drained();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            $error("%0d results never arrived", pending_grants.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_bitmap_slot_allocator_core OK");
        end else begin
            $display("tb_bitmap_slot_allocator_core NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
